// ===== design/salc_pkg.sv =====
// Shared types and codes for the set-associative LRU cache simulator.
// No dependencies; used by every module of the block except salc_ram.
package salc_pkg;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int KIND_W  = 2;
  localparam int OUTC_W  = 2;
  localparam int CNT_W   = 32;
  localparam int SB_W    = 4;
  localparam int BB_W    = 5;
  localparam int WAYS_W  = 4;
  localparam int SHAMT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [SB_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              last;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  eviction_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL_ONE,
    ST_EVAL_FIRST,
    ST_EVAL_SECOND
  } ctl_state_t;

  typedef struct packed {
    logic start;     // latch tag/set, issue set read
    logic clr_step;  // write one reset row
    logic fire;      // resolve access, write row back, load output
    logic second;    // second pass of a modify uses the held row
    logic last;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/salc_ctrl.sv =====
// Controller FSM: reset clearing pass, accept, then zero, one or two resolve passes.
// Depends on salc_pkg.
module salc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [salc_pkg::KIND_W-1:0] in_kind,
  input  salc_pkg::dp_status_t    st,
  output salc_pkg::ctl_cmd_t      cmd
);
  import salc_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (in_kind) inside
            KIND_LOAD, KIND_STORE: state_nxt = ST_EVAL_ONE;
            KIND_MODIFY:           state_nxt = ST_EVAL_FIRST;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EVAL_ONE: begin
        if (st.out_free) begin
          cmd.fire  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EVAL_FIRST: begin
        if (st.out_free) begin
          cmd.fire  = 1'b1;
          state_nxt = ST_EVAL_SECOND;
        end
      end
      ST_EVAL_SECOND: begin
        cmd.second = 1'b1;
        if (st.out_free) begin
          cmd.fire  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ===== design/salc_dpath.sv =====
// Datapath: config registers, address split, set RAM, way lookup, LRU update,
// saturating totals and the output register. Depends on salc_pkg, salc_ram.
module salc_dpath #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  salc_pkg::in_item_t            in_data,
  input  logic                          cfg_valid,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output salc_pkg::out_item_t           out_data,
  input  salc_pkg::ctl_cmd_t            cmd,
  output salc_pkg::dp_status_t          st
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_OFS  = MAX_WAYS;
  localparam int TAG_OFS  = MAX_WAYS * (1 + AGE_W);
  localparam int ROW_W    = MAX_WAYS * (1 + AGE_W + TAG_W);

  // configuration
  logic [SB_W-1:0]   set_bits_r;
  logic [BB_W-1:0]   block_bits_r;
  logic [WAYS_W-1:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BB_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [SB_W-1:0]    sb_eff;
  logic [SHAMT_W-1:0] tag_shamt;
  logic [ADDR_W-1:0]  blk_shift;
  logic [IDX_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag_r;
  logic [IDX_W-1:0]   set_r;

  always_comb begin
    sb_eff = (set_bits_r > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : set_bits_r;
    tag_shamt = SHAMT_W'(sb_eff) + SHAMT_W'(block_bits_r);
    blk_shift = in_data.address >> block_bits_r;
    for (int i = 0; i < IDX_W; i++) begin
      set_idx[i] = blk_shift[i] & (SHAMT_W'(i) < SHAMT_W'(sb_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag_r <= in_data.address >> tag_shamt;
      set_r <= set_idx;
    end
  end

  // clearing pass counter
  logic [IDX_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign st.clr_last = (clr_idx_r == IDX_W'(NUM_SETS - 1));

  // set RAM: one row holds valid bits, ranks and tags of all ways
  logic [ROW_W-1:0] ram_rdata, ram_wdata, row_r, row_cur, row_new, row_clr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.start),
    .raddr (set_idx),
    .rdata (ram_rdata)
  );

  // lookup and LRU update
  logic [MAX_WAYS-1:0] v, used, hit_vec, inv_vec;
  logic [AGE_W-1:0]    age [MAX_WAYS];
  logic [TAG_W-1:0]    tg  [MAX_WAYS];
  logic [WAY_W-1:0]    hit_way, inv_way, vic_way, pick;
  logic [AGE_W-1:0]    vic_age, pick_age;
  logic [OUTC_W-1:0]   outcome;

  always_comb begin
    row_cur = cmd.second ? row_r : ram_rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      v[w]       = row_cur[w];
      age[w]     = row_cur[AGE_OFS + w*AGE_W +: AGE_W];
      tg[w]      = row_cur[TAG_OFS + w*TAG_W +: TAG_W];
      used[w]    = (w == 0) || (5'(w) < {1'b0, ways_r});
      hit_vec[w] = used[w] & v[w] & (tg[w] == tag_r);
      inv_vec[w] = used[w] & ~v[w];
    end

    // lowest-numbered matching / empty way
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
    end

    // oldest used way, lowest index on a tie
    vic_way = '0;
    vic_age = age[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (used[w] && (age[w] > vic_age)) begin
        vic_way = WAY_W'(w);
        vic_age = age[w];
      end
    end

    if (|hit_vec) begin
      pick    = hit_way;
      outcome = OUTC_HIT;
    end else if (|inv_vec) begin
      pick    = inv_way;
      outcome = OUTC_FILL;
    end else begin
      pick    = vic_way;
      outcome = OUTC_EVICT;
    end
    pick_age = age[pick];

    row_new = row_cur;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == pick) begin
        row_new[w]                             = 1'b1;
        row_new[AGE_OFS + w*AGE_W +: AGE_W]    = '0;
        row_new[TAG_OFS + w*TAG_W +: TAG_W]    = tag_r;
      end else if (age[w] < pick_age) begin
        row_new[AGE_OFS + w*AGE_W +: AGE_W]    = age[w] + 1'b1;
      end
    end

    // reset image of a set: nothing valid, way w has rank w
    row_clr = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_clr[AGE_OFS + w*AGE_W +: AGE_W] = AGE_W'(w);
    end

    ram_we    = cmd.clr_step | cmd.fire;
    ram_waddr = cmd.clr_step ? clr_idx_r : set_r;
    ram_wdata = cmd.clr_step ? row_clr : row_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      row_r <= row_new;
    end
  end

  // saturating totals
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (outcome == OUTC_HIT) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
      if ((outcome == OUTC_EVICT) && (evict_cnt_r != '1)) begin
        evict_cnt_nxt = evict_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.fire) begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_data_r.outcome        <= outcome;
      out_data_r.last           <= cmd.last;
      out_data_r.hit_total      <= hit_cnt_nxt;
      out_data_r.miss_total     <= miss_cnt_nxt;
      out_data_r.eviction_total <= evict_cnt_nxt;
    end
  end

  assign st.out_free = ~out_valid_r | out_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

endmodule

// ===== design/set_assoc_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache hit/miss simulator.
// Depends on salc_pkg, salc_ctrl, salc_dpath (and salc_ram below it).
//
//   port group  dir   handshake              payload
//   in_         in    in_valid / in_ready    in_data   (salc_pkg::in_item_t)
//   out_        out   out_valid / out_ready  out_data  (salc_pkg::out_item_t)
//   cfg_        in    cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Load or store: accept + set read, then resolve + row write-back; modify:
// accept + set read, then two resolve passes; kind 3: accept only.
// The single set RAM write port and its registered read set these steps.
// After reset a clearing pass over all 2^MAX_SET_BITS sets initializes the set
// RAM; no input beat is accepted until it ends.
// A full output register holds the resolve step; inputs wait until idle.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  salc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output salc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import salc_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_data.kind),
    .st       (st),
    .cmd      (cmd)
  );

  salc_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
